>>> hdl/sha256_pkg.sv
package sha256_pkg;

  localparam int WordW = 32;
  localparam int BlockWords = 16;
  localparam int Rounds = 64;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_byte;   // write byte into its message window word
    logic       pad_start;   // write 0x80 and zero tail on finish
    logic       pad_zero;    // zero first 56 bytes (extra pad block)
    logic       put_length;  // write bit length into last 8 bytes
    logic       comp_start;  // hash into working vars
    logic       comp_round;  // run one round
    logic       comp_end;    // fold working vars into hash
    logic       add_block;   // message_bits += 512
    logic       reset_hash;  // back to initial values
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
  } dp_status_t;

  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hdl/sha256_stream_hasher_unit.sv
// Channel | Signals                                   | Direction
// in      | in_valid, in_ready, command, message_byte | into block
// out     | out_valid, out_ready, digest_word,        | out of block
//         | word_index, last_word                     |
// A byte is taken on each accepted beat; the 64th byte of a block starts
// a compression (load, 64 rounds of the single round unit, fold).
// Finish: the pad beat, then one or two compressions (the extra block comes
// first), with the length write just before the last one, then eight result beats,
// one per cycle while out_ready is high.
// Synchronous reset restores the initial hash and clears counters.
// in_ready is low while a block compresses or the digest is being delivered.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  message_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] hash_out [8];

  sha256_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .command, .status, .cmd,
    .out_valid, .out_ready, .out_index(word_index)
  );

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .message_byte, .status, .hash_out
  );

  assign digest_word = hash_out[word_index];
  assign last_word = (word_index == 3'd7);

endmodule

>>> hdl/sha256_datapath.sv
module sha256_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::dp_cmd_t    cmd,
  input  logic [7:0]             message_byte,
  output sha256_pkg::dp_status_t status,
  output logic [31:0]            hash_out [8]
);
  import sha256_pkg::*;

  logic [31:0] window [16];
  logic [31:0] pad_word [16];
  logic [31:0] load_word;
  logic [31:0] v [8];
  logic [31:0] hash [8];
  logic [5:0]  fill;
  logic [5:0]  round;
  logic [63:0] message_bits;
  logic [63:0] total;

  // schedule and round logic
  logic [31:0] w_next, w_cur, a2, a15, sg0, sg1, s0, s1, ch, mj, t1, t2;

  assign total = message_bits + {55'd0, fill, 3'd0};

  // incoming byte merged into its window word, big-endian within the word
  always_comb begin
    load_word = window[fill[5:2]];
    case (fill[1:0])
      2'd0: load_word[31:24] = message_byte;
      2'd1: load_word[23:16] = message_byte;
      2'd2: load_word[15:8] = message_byte;
      default: load_word[7:0] = message_byte;
    endcase
  end

  // pad marker at the fill position, zeros after it, message bytes kept
  always_comb begin
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 4; j++)
        if (6'(4*i + j) < fill) pad_word[i][31-8*j -: 8] = window[i][31-8*j -: 8];
        else if (6'(4*i + j) == fill) pad_word[i][31-8*j -: 8] = PadByte;
        else pad_word[i][31-8*j -: 8] = 8'd0;
  end

  always_comb begin
    a2  = window[4'(round - 6'd2)];
    a15 = window[4'(round - 6'd15)];
    sg1 = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
    sg0 = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
    w_next = sg1 + window[4'(round - 6'd7)] + sg0 + window[round[3:0]];
    w_cur = (round < 6'd16) ? window[round[3:0]] : w_next;
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + RoundK[round] + w_cur;
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
  end

  // control counters and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      round <= '0;
      message_bits <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
    end else begin
      if (cmd.load_byte) fill <= fill + 6'd1;
      if (cmd.add_block) message_bits <= message_bits + 64'd512;
      if (cmd.comp_start) round <= '0;
      else if (cmd.comp_round) round <= round + 6'd1;
      if (cmd.comp_end)
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
      if (cmd.reset_hash) begin
        for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
        fill <= '0;
        message_bits <= '0;
      end
    end
  end

  // message window (doubles as schedule) and working variables
  always_ff @(posedge clk) begin
    if (cmd.load_byte) window[fill[5:2]] <= load_word;
    if (cmd.pad_start)
      for (int i = 0; i < 16; i++) window[i] <= pad_word[i];
    if (cmd.pad_zero)
      for (int i = 0; i < 14; i++) window[i] <= '0;
    if (cmd.put_length) begin
      window[14] <= total[63:32];
      window[15] <= total[31:0];
    end
    if (cmd.comp_start)
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    if (cmd.comp_round) begin
      if (round >= 6'd16) window[round[3:0]] <= w_next;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign status.fill = fill;
  assign status.round = round;
  assign hash_out = hash;

endmodule

>>> hdl/sha256_control.sv
module sha256_control (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  sha256_pkg::dp_status_t status,
  output sha256_pkg::dp_cmd_t    cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_index
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_LEN   = 3'd5;

  logic [2:0] state, state_next;
  logic       finishing, finishing_next;  // running the pad blocks
  logic       final_blk, final_blk_next;  // current compression is the last one
  logic [2:0] out_index_next;
  logic       in_beat;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_valid = (state == S_EMIT);

  always_comb begin
    cmd = '0;
    state_next = state;
    finishing_next = finishing;
    final_blk_next = final_blk;
    out_index_next = out_index;
    unique case (state)
      S_IDLE: begin
        if (in_beat) begin
          if (!command) begin
            cmd.load_byte = 1'b1;
            if (status.fill == 6'd63) begin
              state_next = S_START;
              finishing_next = 1'b0;
            end
          end else begin
            cmd.pad_start = 1'b1;
            finishing_next = 1'b1;
            // length goes in now unless an extra block is needed
            final_blk_next = (status.fill < LengthPos);
            state_next = (status.fill < LengthPos) ? S_LEN : S_START;
          end
        end
      end
      S_LEN: begin
        cmd.put_length = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.comp_start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.comp_round = 1'b1;
        if (status.round == 6'd63) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.comp_end = 1'b1;
        if (!finishing) begin
          cmd.add_block = 1'b1;
          state_next = S_IDLE;
        end else if (!final_blk) begin
          cmd.pad_zero = 1'b1;
          final_blk_next = 1'b1;
          state_next = S_LEN;
        end else begin
          out_index_next = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          out_index_next = out_index + 3'd1;
          if (out_index == 3'd7) begin
            cmd.reset_hash = 1'b1;
            finishing_next = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      out_index <= '0;
    end else begin
      state <= state_next;
      finishing <= finishing_next;
      final_blk <= final_blk_next;
      out_index <= out_index_next;
    end
  end

endmodule

>>> test/tb_digest_checker.sv
module tb_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [7:0]  message_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [63:0]  bits_done;
  digest_beat_t digest_q [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one SHA-256 compression of the buffered block into the hash state
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2],
      hash_state[3], hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
           RoundK[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e; hash_state[5] += f;
    hash_state[6] += g; hash_state[7] += h;
  endtask

  // absorb a byte or finish the message
  task automatic take_beat(input logic cmd, input logic [7:0] b);
    logic [63:0] total;
    if (!cmd) begin
      blk[fill] = b;
      fill++;
      if (fill == 64) begin
        compress();
        bits_done += 64'd512;
        fill = 0;
      end
    end else begin
      total = bits_done + 64'(fill) * 8;
      blk[fill] = PadByte;
      for (int i = fill + 1; i < 64; i++) blk[i] = '0;
      if (fill >= 56) begin
        compress();
        for (int i = 0; i < 56; i++) blk[i] = '0;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{hash_state[i], 3'(i), i == 7});
      hash_state = InitHash;
      fill = 0;
      bits_done = '0;
    end
  endtask

  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst) begin
      hash_state = InitHash;
      fill = 0;
      bits_done = '0;
      digest_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat %h idx %0d", $time, digest_word,
                   word_index);
          fail_count <= fail_count + 1;
        end else begin
          exp_beat = digest_q.pop_front();
          if (digest_word !== exp_beat.word || word_index !== exp_beat.idx ||
              last_word !== exp_beat.last) begin
            $display("%0t: mismatch exp %h/%0d/%0b got %h/%0d/%0b", $time,
                     exp_beat.word, exp_beat.idx, exp_beat.last, digest_word,
                     word_index, last_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) take_beat(command, message_byte);
    end
    words_pending = digest_q.size();
  end
endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  message_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          words_pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  localparam int QuietLimit = 20000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sha256_stream_hasher_unit u_top (.*);

  tb_digest_checker u_chk (.*);

  // receiver stalls
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // optional idle cycles, then present one beat and wait until taken
  task automatic send_beat(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    message_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_message(input int len, input int fill_kind);
    for (int i = 0; i < len; i++)
      case (fill_kind)
        0: send_beat(1'b0, 8'h00);
        1: send_beat(1'b0, 8'hff);
        default: send_beat(1'b0, 8'($urandom));
      endcase
    send_beat(1'b1, 8'($urandom));
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty message, padding boundaries, byte extremes
    send_message(0, 2);
    send_message(1, 0);
    send_message(3, 1);
    send_message(55, 2);
    send_message(56, 2);
    send_message(63, 1);
    send_message(64, 0);
    send_beat(1'b1, 8'h00);
    // random messages across idling phases, mostly short ones
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 82 : (ph == 3) ? 20 : 0;
      recv_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 20 : 0;
      sent = 0;
      while (sent < 25) begin
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(20);
        send_message(len, 2);
        sent += len + 1;
      end
    end
    in_valid <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
